@@ sv/slfd_pkg.sv @@
`default_nettype none
package slfd_pkg;

    typedef logic [7:0] t_byte;

    localparam int    SLFD_HEADER_BYTES = 4;
    localparam t_byte SYNC_MARK_RST     = 8'hFF;
    localparam int    REM_W             = 9;

endpackage
`default_nettype wire

@@ sv/slfd_ifs.sv @@
`default_nettype none
interface slfd_cfg_if
    import slfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte sync_mark;

    modport source (output valid, output sync_mark, input ready);
    modport sink   (input valid, input sync_mark, output ready);
endinterface

interface slfd_rx_if
    import slfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_frm_if
    import slfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte frame_byte;
    logic  frame_first;
    logic  frame_last;

    modport source (output valid, output frame_byte, output frame_first, output frame_last,
                    input ready);
    modport sink   (input valid, input frame_byte, input frame_first, input frame_last,
                    output ready);
endinterface
`default_nettype wire

@@ sv/start_length_frame_deframer_core.sv @@
`default_nettype none
// Length-prefixed frame deframer. Takes one received byte per cycle, save while a header burst
// runs or the output is stalled, and passes out the bytes of each frame whose length byte is
// nonzero: header (start mark flagged first), length, payload, and the end byte flagged last.
// Bytes outside a frame and frames of length zero are dropped. The length byte puts the start
// mark out and starts a burst that plays the other HEADER_BYTES held bytes (rest of header and
// length) out of the header registers, one per output transfer; input is held off while the
// burst runs. A result sits in the output register while the next byte is taken. sync_mark
// may be written at any idle time and resets to 0xFF.
module start_length_frame_deframer_core
    import slfd_pkg::*;
#(
    parameter int HEADER_BYTES = SLFD_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfd_cfg_if.sink    i_cfg,
    slfd_rx_if.sink     i_rx,
    slfd_frm_if.source  o_frm
);

    localparam int POS_W = $clog2(HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_ZERO = '0;
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_BODY} t_phase;

    t_phase             r_phase, n_phase;
    t_byte              r_sync_mark, n_sync_mark;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic               r_burst, n_burst;
    logic [POS_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    t_byte              r_out_byte, n_out_byte;
    logic               r_out_first, n_out_first;
    logic               r_out_last, n_out_last;

    t_byte              r_hdr [HEADER_BYTES+1];
    logic               hdr_we;
    logic [POS_W-1:0]   hdr_wa;

    logic               out_free;
    logic               rx_ready;
    logic               take;
    t_byte              b;

    assign out_free = !r_out_valid || o_frm.ready;
    assign rx_ready = !r_burst && out_free;
    assign take     = i_rx.valid && rx_ready;
    assign b        = i_rx.rx_byte;

    assign i_rx.ready        = rx_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_frm.valid       = r_out_valid;
    assign o_frm.frame_byte  = r_out_byte;
    assign o_frm.frame_first = r_out_first;
    assign o_frm.frame_last  = r_out_last;

    always_comb begin
        n_phase      = r_phase;
        n_sync_mark  = r_sync_mark;
        n_pos        = r_pos;
        n_rem        = r_rem;
        n_burst      = r_burst;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;
        hdr_we       = 1'b0;
        hdr_wa       = POS_ZERO;

        if (i_cfg.valid) begin
            n_sync_mark = i_cfg.sync_mark;
        end

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        // play held header and length out, one per transfer
        if (r_burst && out_free) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_hdr[r_idx];
            n_out_first = 1'b0;
            n_out_last  = 1'b0;
            if (r_idx == POS_LAST) begin
                n_burst = 1'b0;
            end else begin
                n_idx = r_idx + POS_ONE;
            end
        end

        if (take) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (b == r_sync_mark) begin
                        hdr_we  = 1'b1;
                        hdr_wa  = POS_ZERO;
                        n_pos   = POS_ONE;
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (r_pos == POS_ONE && (HEADER_BYTES > 1) && b == r_sync_mark) begin
                        // repeated mark restarts the frame
                        hdr_we = 1'b1;
                        hdr_wa = POS_ZERO;
                    end else if (r_pos < POS_LAST) begin
                        hdr_we = 1'b1;
                        hdr_wa = r_pos;
                        n_pos  = r_pos + POS_ONE;
                    end else begin
                        n_pos = POS_ZERO;
                        if (b == 8'd0) begin
                            n_phase = PH_HUNT;
                        end else begin
                            hdr_we      = 1'b1;
                            hdr_wa      = POS_LAST;
                            n_out_valid = 1'b1;
                            n_out_byte  = r_hdr[0];
                            n_out_first = 1'b1;
                            n_out_last  = 1'b0;
                            n_rem       = {1'b0, b} + REM_ONE;
                            n_burst     = 1'b1;
                            n_idx       = POS_ONE;
                            n_phase     = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = b;
                    n_out_first = 1'b0;
                    n_out_last  = (r_rem <= REM_ONE);
                    if (r_rem <= REM_ONE) begin
                        n_rem   = '0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_rem = r_rem - REM_ONE;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
        r_idx       <= n_idx;
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_sync_mark  <= SYNC_MARK_RST;
            r_pos        <= POS_ZERO;
            r_rem        <= '0;
            r_burst      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_sync_mark  <= n_sync_mark;
            r_pos        <= n_pos;
            r_rem        <= n_rem;
            r_burst      <= n_burst;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[hdr_wa] <= b;
        end
    end

endmodule
`default_nettype wire

@@ sv/slfd_checker.sv @@
`default_nettype none
module slfd_checker
    import slfd_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_cfg_ready,
    input wire logic  i_rx_ready,
    input wire logic  o_frm_valid,
    input wire logic  o_frm_ready,
    input wire t_byte o_frm_byte,
    input wire logic  o_frm_first,
    input wire logic  o_frm_last
);

    // a frame's start byte is never also its end byte
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm_valid |-> !(o_frm_first && o_frm_last))
        else $error("start and end flag on one transfer");

    // input must hold off while a result is stalled
    a_stall_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frm_valid && !o_frm_ready) |-> !i_rx_ready)
        else $error("input taken while output stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("config channel not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frm_valid && !o_frm_ready) |=>
            (o_frm_valid && $stable(o_frm_byte) && $stable(o_frm_first)
             && $stable(o_frm_last)))
        else $error("stalled output changed");

endmodule

bind start_length_frame_deframer_core slfd_checker u_slfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_rx_ready  (i_rx.ready),
    .o_frm_valid (o_frm.valid),
    .o_frm_ready (o_frm.ready),
    .o_frm_byte  (o_frm.frame_byte),
    .o_frm_first (o_frm.frame_first),
    .o_frm_last  (o_frm.frame_last)
);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import slfd_pkg::*;

    localparam int HB          = SLFD_HEADER_BYTES;
    localparam int SETTLE      = 2 * HB + 4;
    localparam int RANDOM_BYTES = 300;

    typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_BODY} t_phase;

    typedef struct packed {
        t_byte data;
        logic  first;
        logic  last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    slfd_cfg_if cfg_bus();
    slfd_rx_if  rx_bus();
    slfd_frm_if frm_bus();

    start_length_frame_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_rx    (rx_bus),
        .o_frm   (frm_bus)
    );

    // deframer mirror
    t_byte  mark_m;
    t_phase phase_m;
    t_byte  hdr_m [HB];
    int     hpos_m;
    int     remaining_m;

    t_beat  pending_beats [$];
    t_beat  head_beat;

    bit     src_idle_en;
    bit     sink_idle_en;
    int     hold_req;

    int     error_count;
    int     rx_sent;
    int     beats_seen;
    int     frames_seen;
    int     marks_written;
    int     zero_len_frames;
    int     max_len_frames;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d beats still pending", pending_beats.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void push_beat(input t_byte d, input logic f, input logic l);
        t_beat b;
        b.data  = d;
        b.first = f;
        b.last  = l;
        pending_beats.push_back(b);
    endfunction

    // Advance the mirror by one accepted byte and queue the bytes it releases.
    function automatic void deframe_byte(input t_byte b);
        case (phase_m)
            PH_HUNT: begin
                if (b == mark_m) begin
                    hdr_m[0] = b;
                    hpos_m   = 1;
                    phase_m  = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (hpos_m == 1 && HB > 1 && b == mark_m) begin
                    hdr_m[0] = b;
                end else if (hpos_m < HB) begin
                    hdr_m[hpos_m] = b;
                    hpos_m++;
                end else if (b == 8'd0) begin
                    phase_m = PH_HUNT;
                    hpos_m  = 0;
                    zero_len_frames++;
                end else begin
                    for (int i = 0; i < HB; i++)
                        push_beat(hdr_m[i], i == 0, 1'b0);
                    push_beat(b, 1'b0, 1'b0);
                    remaining_m = int'(b) + 1;
                    hpos_m      = 0;
                    phase_m     = PH_BODY;
                    if (b == 8'hFF)
                        max_len_frames++;
                end
            end
            default: begin
                if (remaining_m <= 1) begin
                    push_beat(b, 1'b0, 1'b1);
                    remaining_m = 0;
                    phase_m     = PH_HUNT;
                end else begin
                    push_beat(b, 1'b0, 1'b0);
                    remaining_m--;
                end
            end
        endcase
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Output side: compare every transfer with the oldest pending beat.
    always @(posedge i_clk) begin
        if (i_rst_n && frm_bus.valid && frm_bus.ready) begin
            beats_seen++;
            if (frm_bus.frame_last === 1'b1)
                frames_seen++;
            if (pending_beats.size() == 0) begin
                note_error($sformatf("unexpected beat: byte %h first %b last %b",
                                     frm_bus.frame_byte, frm_bus.frame_first,
                                     frm_bus.frame_last));
            end else begin
                head_beat = pending_beats.pop_front();
                if (frm_bus.frame_byte !== head_beat.data ||
                    frm_bus.frame_first !== head_beat.first ||
                    frm_bus.frame_last !== head_beat.last)
                    note_error($sformatf(
                        "beat mismatch: expected %h/%b/%b, got %h/%b/%b",
                        head_beat.data, head_beat.first, head_beat.last,
                        frm_bus.frame_byte, frm_bus.frame_first, frm_bus.frame_last));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        frm_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                frm_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            frm_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!frm_bus.valid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input t_byte b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        deframe_byte(b);
        rx_sent++;
    endtask

    // Drop valid and hold until every expected beat is out and the block has settled.
    task automatic wait_idle();
        rx_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mark(input t_byte m);
        cfg_bus.sync_mark <= m;
        cfg_bus.valid     <= 1'b1;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        mark_m = m;
        marks_written++;
    endtask

    // Well-formed frame with random content; optional repeated start mark.
    task automatic send_frame(input int len, input bit restart);
        send_byte(mark_m);
        if (restart)
            send_byte(mark_m);
        for (int i = 1; i < HB; i++)
            send_byte(t_byte'($urandom_range(0, 255)));
        send_byte(t_byte'(len));
        if (len != 0) begin
            for (int i = 0; i <= len; i++)
                send_byte(($urandom_range(0, 7) == 0) ? mark_m
                                                      : t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        // noise while hunting
        send_byte(8'h00);
        send_byte(8'h12);
        // repeated start mark, then the mark again as payload
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        // zero length: whole frame dropped
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h00);
        // start mark past the first header position is plain data
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h02);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hFF);
        wait_idle();
    endtask

    task automatic test_marks();
        t_byte marks [4];
        marks = '{8'h00, 8'h7E, t_byte'($urandom_range(1, 254)), 8'hFF};
        foreach (marks[k]) begin
            wait_idle();
            write_mark(marks[k]);
            send_byte(marks[k] ^ 8'h01);
            send_frame(2, 1'b0);
            send_frame(0, 1'b0);
            send_frame(1, 1'b1);
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_req    = 120;
        for (int f = 0; f < 4; f++)
            send_frame(3, 1'b0);
        src_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int start_count;
        int sel;
        int frames;
        bit did_max;
        start_count = rx_sent;
        frames      = 0;
        did_max     = 1'b0;
        write_mark(t_byte'($urandom_range(0, 255)));
        while (rx_sent - start_count < RANDOM_BYTES) begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (!did_max && frames == 6) begin
                did_max = 1'b1;
                send_frame(255, 1'b0);
            end else if (sel <= 5) begin
                send_frame($urandom_range(1, 8), $urandom_range(0, 4) == 0);
            end else if (sel == 6) begin
                send_frame($urandom_range(9, 40), 1'b0);
            end else if (sel == 7) begin
                send_frame(0, 1'($urandom_range(0, 1)));
            end else if (sel == 8) begin
                repeat ($urandom_range(1, 4))
                    send_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                // truncated header: the next frame's bytes land inside it
                send_byte(mark_m);
                repeat ($urandom_range(0, HB - 2))
                    send_byte(t_byte'($urandom_range(0, 255)));
            end
            frames++;
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        int waited;
        mark_m          = SYNC_MARK_RST;
        phase_m         = PH_HUNT;
        hpos_m          = 0;
        remaining_m     = 0;
        src_idle_en     = 1'b1;
        sink_idle_en    = 1'b1;
        hold_req        = 0;
        error_count     = 0;
        rx_sent         = 0;
        beats_seen      = 0;
        frames_seen     = 0;
        marks_written   = 0;
        zero_len_frames = 0;
        max_len_frames  = 0;
        foreach (hdr_m[i]) hdr_m[i] = 8'h00;

        i_rst_n           <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.sync_mark <= 8'h00;
        rx_bus.valid      <= 1'b0;
        rx_bus.rx_byte    <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_marks();
        test_backpressure();
        test_random_frames();

        rx_bus.valid <= 1'b0;
        waited = 0;
        while (pending_beats.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_beats.size() != 0)
            note_error($sformatf("%0d expected beats never arrived", pending_beats.size()));

        $display("sent %0d rx bytes, checked %0d frame bytes in %0d frames", rx_sent,
                 beats_seen, frames_seen);
        $display("start mark written %0d times; %0d zero-length, %0d max-length frames",
                 marks_written, zero_len_frames, max_len_frames);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/slfd_pkg.sv
sv/slfd_ifs.sv
sv/start_length_frame_deframer_core.sv
sv/slfd_checker.sv
verif/tb.sv
